### hw/rtl/front_middle_back_queue_macros.svh
// assertion macros for the queue rtl
// no dependencies; included by files that carry concurrent checks
`ifndef FRONT_MIDDLE_BACK_QUEUE_MACROS_SVH
`define FRONT_MIDDLE_BACK_QUEUE_MACROS_SVH

// same-cycle implication, disabled while in reset
`define FMBQ_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fmbq check failed");

// next-cycle implication, disabled while in reset
`define FMBQ_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fmbq check failed");

`endif

### hw/rtl/fmbq_pkg.sv
// shared types and codes for the front/middle/back queue
// no dependencies; used by the controller, datapath and top level
package fmbq_pkg;

    localparam logic [2:0] OP_PUSH_FRONT  = 3'd0;
    localparam logic [2:0] OP_PUSH_MIDDLE = 3'd1;
    localparam logic [2:0] OP_PUSH_BACK   = 3'd2;
    localparam logic [2:0] OP_POP_FRONT   = 3'd3;
    localparam logic [2:0] OP_POP_MIDDLE  = 3'd4;
    localparam logic [2:0] OP_POP_BACK    = 3'd5;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [31:0] value;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] popped;
        logic [1:0]         status;
        logic [4:0]         occupancy;
    } t_out_word;

    // controller to datapath
    typedef struct packed {
        logic start;     // latch the incoming word
        logic plan;      // set pointers and status from op and count
        logic take_rd;   // read the word being removed
        logic take;      // capture the removed word
        logic shift_rd;  // read neighbor of the current slot
        logic shift_wr;  // write neighbor into current slot, step pointer
        logic place;     // write the pushed word, count up
        logic dec;       // count down after a pop
        logic load_out;  // load the output register
    } t_fmbq_cmd;

    // datapath to controller
    typedef struct packed {
        logic push;
        logic pop;
        logic full;
        logic empty;
        logic at_stop;
        logic out_free;
    } t_fmbq_sts;

endpackage

### hw/rtl/fmbq_ctrl.sv
// controller state machine for the front/middle/back queue
// depends on fmbq_pkg for the command and status structs
module fmbq_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  fmbq_pkg::t_fmbq_sts   i_sts,
    output fmbq_pkg::t_fmbq_cmd   o_cmd
);
    import fmbq_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_PLAN     = 8'b0000_0010,
        S_TAKE_RD  = 8'b0000_0100,
        S_TAKE     = 8'b0000_1000,
        S_SHIFT_RD = 8'b0001_0000,
        S_SHIFT_WR = 8'b0010_0000,
        S_PLACE    = 8'b0100_0000,
        S_DONE     = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_PLAN;
                end
            end
            S_PLAN: begin
                o_cmd.plan = 1'b1;
                if (i_sts.push) begin
                    n_state = i_sts.full ? S_DONE : S_SHIFT_RD;
                end else if (i_sts.pop) begin
                    n_state = i_sts.empty ? S_DONE : S_TAKE_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_TAKE_RD: begin
                o_cmd.take_rd = 1'b1;
                n_state       = S_TAKE;
            end
            S_TAKE: begin
                o_cmd.take = 1'b1;
                n_state    = S_SHIFT_RD;
            end
            S_SHIFT_RD: begin
                if (i_sts.at_stop) begin
                    if (i_sts.push) begin
                        n_state = S_PLACE;
                    end else begin
                        o_cmd.dec = 1'b1;
                        n_state   = S_DONE;
                    end
                end else begin
                    o_cmd.shift_rd = 1'b1;
                    n_state        = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                o_cmd.shift_wr = 1'b1;
                n_state        = S_SHIFT_RD;
            end
            S_PLACE: begin
                o_cmd.place = 1'b1;
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### hw/rtl/fmbq_dpath.sv
// datapath for the front/middle/back queue: word memory, count, pointers, output register
// depends on fmbq_pkg and front_middle_back_queue_macros.svh
`include "front_middle_back_queue_macros.svh"

module fmbq_dpath #(
    parameter int CAPACITY = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  fmbq_pkg::t_fmbq_cmd   i_cmd,
    input  fmbq_pkg::t_in_word    i_in_word,
    input  logic                  i_out_stall,
    output fmbq_pkg::t_fmbq_sts   o_sts,
    output logic                  o_out_valid,
    output fmbq_pkg::t_out_word   o_out_word
);
    import fmbq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic [31:0]        r_mem [CAPACITY];
    logic [31:0]        r_rd;
    logic [2:0]         r_op;
    logic signed [31:0] r_value;
    logic [CW-1:0]      r_count;
    logic [AW-1:0]      r_ptr;
    logic [AW-1:0]      r_stop;
    logic signed [31:0] r_popped;
    logic [1:0]         r_status;
    logic               r_out_valid;
    t_out_word          r_out_word;

    logic               w_push;
    logic               w_pop;
    logic               w_full;
    logic               w_empty;
    logic [CW-1:0]      w_cnt_m1;
    logic [CW-1:0]      w_half;
    logic [CW-1:0]      w_half_m1;
    logic [AW-1:0]      w_plan_ptr;
    logic [AW-1:0]      w_plan_stop;
    logic [1:0]         w_plan_status;
    logic signed [31:0] w_plan_popped;
    logic               w_rd_en;
    logic [AW-1:0]      w_rd_addr;
    logic               w_wr_en;
    logic [31:0]        w_wr_data;

    assign w_push    = (r_op <= OP_PUSH_BACK);
    assign w_pop     = !w_push && (r_op <= OP_POP_BACK);
    assign w_full    = (r_count >= CW'(CAPACITY));
    assign w_empty   = (r_count == '0);
    assign w_cnt_m1  = r_count - CW'(1);
    assign w_half    = r_count >> 1;
    assign w_half_m1 = w_cnt_m1 >> 1;

    // push walks down from count to the insert slot, pop walks up from the removed slot
    always_comb begin
        w_plan_ptr  = '0;
        w_plan_stop = '0;
        case (r_op)
            OP_PUSH_FRONT: begin
                w_plan_ptr  = r_count[AW-1:0];
                w_plan_stop = '0;
            end
            OP_PUSH_MIDDLE: begin
                w_plan_ptr  = r_count[AW-1:0];
                w_plan_stop = w_half[AW-1:0];
            end
            OP_PUSH_BACK: begin
                w_plan_ptr  = r_count[AW-1:0];
                w_plan_stop = r_count[AW-1:0];
            end
            OP_POP_FRONT: begin
                w_plan_ptr  = '0;
                w_plan_stop = w_cnt_m1[AW-1:0];
            end
            OP_POP_MIDDLE: begin
                w_plan_ptr  = w_half_m1[AW-1:0];
                w_plan_stop = w_cnt_m1[AW-1:0];
            end
            OP_POP_BACK: begin
                w_plan_ptr  = w_cnt_m1[AW-1:0];
                w_plan_stop = w_cnt_m1[AW-1:0];
            end
            default: begin
                w_plan_ptr  = '0;
                w_plan_stop = '0;
            end
        endcase
    end

    always_comb begin
        w_plan_popped = '0;
        w_plan_status = ST_DONE;
        if (w_push && w_full) begin
            w_plan_status = ST_FULL;
        end else if (w_pop && w_empty) begin
            w_plan_popped = '1;
            w_plan_status = ST_EMPTY;
        end
    end

    assign w_rd_en   = i_cmd.take_rd || i_cmd.shift_rd;
    assign w_rd_addr = i_cmd.take_rd ? r_ptr :
                       (w_push ? r_ptr - AW'(1) : r_ptr + AW'(1));
    assign w_wr_en   = i_cmd.shift_wr || i_cmd.place;
    assign w_wr_data = i_cmd.place ? r_value : r_rd;

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_ptr] <= w_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op    <= i_in_word.op;
            r_value <= i_in_word.value;
        end
        if (i_cmd.plan) begin
            r_ptr    <= w_plan_ptr;
            r_stop   <= w_plan_stop;
            r_popped <= w_plan_popped;
            r_status <= w_plan_status;
        end else if (i_cmd.shift_wr) begin
            r_ptr <= w_push ? r_ptr - AW'(1) : r_ptr + AW'(1);
        end
        if (i_cmd.take) begin
            r_popped <= r_rd;
        end
        if (i_cmd.load_out) begin
            r_out_word.popped    <= r_popped;
            r_out_word.status    <= r_status;
            r_out_word.occupancy <= 5'(r_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.place) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.dec) begin
                r_count <= w_cnt_m1;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.push     = w_push;
    assign o_sts.pop      = w_pop;
    assign o_sts.full     = w_full;
    assign o_sts.empty    = w_empty;
    assign o_sts.at_stop  = (r_ptr == r_stop);
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    `FMBQ_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(CAPACITY))
    `FMBQ_ASSERT_IMP(a_place_room, i_clk, i_rst_n, i_cmd.place, r_count < CW'(CAPACITY))
    `FMBQ_ASSERT_NXT(a_count_hold, i_clk, i_rst_n, !i_cmd.place && !i_cmd.dec, $stable(r_count))
    `FMBQ_ASSERT_IMP(a_empty_word, i_clk, i_rst_n, o_out_valid && o_out_word.status == ST_EMPTY, o_out_word.popped == '1 && o_out_word.occupancy == '0)

endmodule

### hw/rtl/front_middle_back_queue.sv
// top level of the front/middle/back queue: controller plus datapath
// depends on fmbq_pkg, fmbq_ctrl and fmbq_dpath
//
//   channel   direction   handshake               word
//   in        input       i_in_valid / o_in_stall  op, value
//   out       output      o_out_valid / i_out_stall popped, status, occupancy
//
// one operation at a time; the memory has one port per direction, so each shifted
// word is read in S_SHIFT_RD and written in S_SHIFT_WR; a pop first reads and takes
// the removed word, a push ends in S_PLACE; full, empty and unknown ops go to S_DONE
// a result waits in the output register, the next word is taken while it is stalled
// reset clears the count and the control state at once, no clearing pass is needed
module front_middle_back_queue #(
    parameter int CAPACITY = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  fmbq_pkg::t_in_word   i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output fmbq_pkg::t_out_word  o_out_word
);
    import fmbq_pkg::*;

    t_fmbq_cmd w_cmd;
    t_fmbq_sts w_sts;

    fmbq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    fmbq_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_in_word   (i_in_word),
        .i_out_stall (i_out_stall),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
// testbench for front_middle_back_queue: a directed table, then biased random operations
// depends on fmbq_pkg and the queue rtl; a shift-queue copy predicts results rows do not fix

module tb_top;
    import fmbq_pkg::*;

    localparam int CAPACITY       = 16;
    localparam int RANDOM_ITEMS   = 1325;
    localparam int QUIET_ITEMS    = 150;
    localparam int SEGMENT_ITEMS  = 40;
    localparam int PAUSE_EVERY    = 250;
    localparam int DRAIN_CYCLES   = 60;
    localparam int WATCHDOG_LIMIT = 2000;

    // operation codes the block ignores
    localparam logic [2:0] OP_RSVD6 = 3'd6;
    localparam logic [2:0] OP_RSVD7 = 3'd7;

    localparam logic signed [31:0] WORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] WORD_NEG1 = -32'sd1;

    typedef struct {
        t_in_word  word;
        bit        typed;
        t_out_word want;
    } t_row;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_word  i_in_word   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_word o_out_word;

    // predictor state
    logic signed [31:0] model_slots [CAPACITY];
    int                 model_count = 0;

    t_out_word due_results [$];
    t_row      directed_rows [$];

    int send_gap_pct    = 20;
    int recv_gap_pct    = 20;
    int stall_left      = 0;
    int error_count     = 0;
    int items_sent      = 0;
    int results_checked = 0;
    int empty_pops      = 0;
    int full_pushes     = 0;
    t_out_word head_result;

    front_middle_back_queue #(
        .CAPACITY(CAPACITY)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_word (o_out_word)
    );

    always #10 i_clk = ~i_clk;

    // apply one operation to the local queue copy and return the result it gives
    function automatic t_out_word apply_queue_op(input t_in_word w);
        t_out_word r;
        int        pos;
        r        = '0;
        r.status = ST_DONE;
        pos      = 0;
        if (w.op <= OP_PUSH_BACK) begin
            if (model_count >= CAPACITY) begin
                r.status = ST_FULL;
            end else begin
                case (w.op)
                    OP_PUSH_FRONT:  pos = 0;
                    OP_PUSH_MIDDLE: pos = model_count / 2;
                    default:        pos = model_count;
                endcase
                for (int k = model_count; k > pos; k--) model_slots[k] = model_slots[k-1];
                model_slots[pos] = w.value;
                model_count++;
            end
        end else if (w.op <= OP_POP_BACK) begin
            if (model_count == 0) begin
                r.popped = WORD_NEG1;
                r.status = ST_EMPTY;
            end else begin
                case (w.op)
                    OP_POP_FRONT:  pos = 0;
                    OP_POP_MIDDLE: pos = (model_count - 1) / 2;
                    default:       pos = model_count - 1;
                endcase
                r.popped = model_slots[pos];
                for (int k = pos; k + 1 < model_count; k++) model_slots[k] = model_slots[k+1];
                model_count--;
            end
        end
        r.occupancy = model_count[4:0];
        return r;
    endfunction

    task automatic add_row(input logic [2:0] op, input logic signed [31:0] value,
                           input bit typed, input t_out_word want);
        t_row row;
        row.word.op    = op;
        row.word.value = value;
        row.typed      = typed;
        row.want       = want;
        directed_rows.insert(directed_rows.size(), row);
    endtask

    // offer one word, hold it until taken, then record what it should produce
    task automatic send_op(input t_in_word w, input bit typed, input t_out_word want);
        int        gap;
        t_out_word got;
        if (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) begin
            gap = $urandom_range(9, 1);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        got = apply_queue_op(w);
        due_results.insert(due_results.size(), typed ? want : got);
        items_sent++;
    endtask

    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (due_results.size() != 0) @(posedge i_clk);
    endtask

    // receiver stall bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (recv_gap_pct > 0 && $urandom_range(99) < recv_gap_pct) begin
            stall_left  <= $urandom_range(9, 1) - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (o_out_word.status == ST_EMPTY) empty_pops++;
            if (o_out_word.status == ST_FULL) full_pushes++;
            if (due_results.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result: popped %0d status %0d occupancy %0d",
                         $time, o_out_word.popped, o_out_word.status, o_out_word.occupancy);
            end else begin
                head_result = due_results.pop_front();
                results_checked++;
                if (o_out_word.popped !== head_result.popped) begin
                    error_count++;
                    $display("%0t: popped: expected %0d, got %0d",
                             $time, head_result.popped, o_out_word.popped);
                end
                if (o_out_word.status !== head_result.status) begin
                    error_count++;
                    $display("%0t: status: expected %0d, got %0d",
                             $time, head_result.status, o_out_word.status);
                end
                if (o_out_word.occupancy !== head_result.occupancy) begin
                    error_count++;
                    $display("%0t: occupancy: expected %0d, got %0d",
                             $time, head_result.occupancy, o_out_word.occupancy);
                end
            end
        end
    end

    // watchdog on cycles with no handshake on either channel
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: watchdog: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        t_in_word w;
        int       n;
        int       sel;
        int       push_pct;
        int       roll;

        // empty store, ignored codes, a fill to capacity, an overflow, one pop of each kind
        add_row(OP_POP_FRONT,   32'sd5,        1'b1, {WORD_NEG1, ST_EMPTY, 5'd0});
        add_row(OP_POP_MIDDLE,  WORD_MAX,      1'b1, {WORD_NEG1, ST_EMPTY, 5'd0});
        add_row(OP_POP_BACK,    WORD_MIN,      1'b1, {WORD_NEG1, ST_EMPTY, 5'd0});
        add_row(OP_RSVD6,       WORD_NEG1,     1'b1, {32'sd0, ST_DONE, 5'd0});
        add_row(OP_RSVD7,       WORD_MAX,      1'b1, {32'sd0, ST_DONE, 5'd0});
        add_row(OP_PUSH_BACK,   WORD_MAX,      1'b0, '0);
        add_row(OP_PUSH_FRONT,  WORD_MIN,      1'b0, '0);
        add_row(OP_PUSH_MIDDLE, WORD_NEG1,     1'b0, '0);
        add_row(OP_PUSH_MIDDLE, 32'sd0,        1'b0, '0);
        add_row(OP_PUSH_BACK,   32'sh5555_5555, 1'b0, '0);
        add_row(OP_PUSH_FRONT,  32'shAAAA_AAAA, 1'b0, '0);
        add_row(OP_PUSH_MIDDLE, 32'sd1,        1'b0, '0);
        add_row(OP_PUSH_BACK,   -32'sd2,       1'b0, '0);
        add_row(OP_PUSH_FRONT,  32'sh0000_FFFF, 1'b0, '0);
        add_row(OP_PUSH_MIDDLE, 32'shFFFF_0000, 1'b0, '0);
        add_row(OP_PUSH_BACK,   32'sh1234_5678, 1'b0, '0);
        add_row(OP_PUSH_FRONT,  32'sh8000_0001, 1'b0, '0);
        add_row(OP_PUSH_MIDDLE, 32'sh7FFF_FFFE, 1'b0, '0);
        add_row(OP_PUSH_BACK,   32'sh0F0F_0F0F, 1'b0, '0);
        add_row(OP_PUSH_FRONT,  32'shF0F0_F0F0, 1'b0, '0);
        add_row(OP_PUSH_MIDDLE, 32'sh3C3C_C3C3, 1'b0, '0);
        add_row(OP_PUSH_BACK,   32'sd42,       1'b1, {32'sd0, ST_FULL, 5'd16});
        add_row(OP_POP_MIDDLE,  32'sd0,        1'b0, '0);
        add_row(OP_POP_FRONT,   WORD_NEG1,     1'b0, '0);
        add_row(OP_POP_BACK,    32'sd7,        1'b0, '0);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_op(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want);
        wait_for_results();

        push_pct = 50;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            // each segment leans toward filling, draining or neither
            if (n % SEGMENT_ITEMS == 0 || n == RANDOM_ITEMS - QUIET_ITEMS) begin
                case ($urandom_range(2))
                    0:       push_pct = 25;
                    1:       push_pct = 50;
                    default: push_pct = 75;
                endcase
                if (n >= RANDOM_ITEMS - QUIET_ITEMS) begin
                    send_gap_pct = 0;
                    recv_gap_pct = 0;
                end else begin
                    sel = $urandom_range(2);
                    send_gap_pct = (sel == 0) ? 0 : (sel == 1) ? 10 : 35;
                    sel = $urandom_range(2);
                    recv_gap_pct = (sel == 0) ? 0 : (sel == 1) ? 10 : 35;
                end
            end
            if (n > 0 && n % PAUSE_EVERY == 0)
                wait_for_results();

            roll = $urandom_range(99);
            if (roll < 3)
                w.op = 3'($urandom_range(OP_RSVD7, OP_RSVD6));
            else if (roll < 3 + push_pct * 97 / 100)
                w.op = 3'($urandom_range(OP_PUSH_BACK, OP_PUSH_FRONT));
            else
                w.op = 3'($urandom_range(OP_POP_BACK, OP_POP_FRONT));
            case ($urandom_range(9))
                0:       w.value = WORD_MAX;
                1:       w.value = WORD_MIN;
                2:       w.value = WORD_NEG1;
                3:       w.value = 32'sd0;
                4:       w.value = $urandom_range(255);
                default: w.value = $urandom;
            endcase
            send_op(w, 1'b0, '0);
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d operations sent, %0d results checked", items_sent, results_checked);
        $display("%0d pops on an empty queue, %0d pushes on a full one", empty_pops, full_pushes);
        if (error_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/fmbq_pkg.sv
hw/rtl/fmbq_ctrl.sv
hw/rtl/fmbq_dpath.sv
hw/rtl/front_middle_back_queue.sv
tb/sv/tb_top.sv
